[hdl/assert_macros.svh]
// Assertion macros for the top-level RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

[hdl/scfp_pkg.sv]
// Package for the serial command frame parser: payload types, control structs, constants.
`default_nettype none

package scfp_pkg;

   // Frame format
   localparam logic [7:0] StartByte   = 8'h24;   // '$'
   localparam logic [7:0] ProtoByte   = 8'h4D;   // 'M'
   localparam logic [7:0] DirByte     = 8'h3C;   // '<'
   localparam int         MaxPayload  = 64;
   localparam int         StoreDepth  = 64;
   localparam int         StoreAw     = $clog2(StoreDepth);
   localparam logic [31:0] TimeoutReset = 32'd200000;

   // Input request
   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [31:0] now_us;
   } scfp_req_type;

   // One result of an accepted frame
   typedef struct packed {
      logic [7:0] cmd_code;
      logic [6:0] payload_length;
      logic       has_payload;
      logic [5:0] payload_index;
      logic [7:0] payload_byte;
      logic       last;
   } scfp_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture_time;   // remember arrival time of accepted byte
      logic clear_frame;    // header done: clear checksum and length
      logic load_length;    // take length byte
      logic load_command;   // take command byte
      logic store_payload;  // write payload byte to store
      logic start_emit;     // checksum good: rewind read index
      logic fetch;          // read store at read index
      logic send;           // load output register, advance read index
   } scfp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic timed_out;
      logic is_start;
      logic is_proto;
      logic is_dir;
      logic length_ok;
      logic length_zero;
      logic fill_done;
      logic xor_match;
      logic emit_last;
      logic can_load;
   } scfp_stat_type;

endpackage

`default_nettype wire

[hdl/serial_command_frame_parser.sv]
// Top level of the serial command frame parser: controller, datapath and checks.
//
//   Channel  Ports                          Flow control  Moves
//   req      req_valid req_stall req_data   valid/stall   one received byte with time
//   rsp      rsp_valid rsp_stall rsp_data   valid/stall   one result of a good frame
//   csr      csr_valid csr_ready csr_data   valid/ready   timeout_limit write
//
// Byte requests are taken without stall while the parser is hunting or inside a frame.
// After a good checksum byte, a frame gives one result per payload byte (one if empty),
// each byte read through the registered read port of the payload store; byte requests
// stall during that time, longer while a result waits on rsp_stall.
// Synchronous reset returns to hunting, clears the last arrival time and loads
// timeout_limit with 200000; a stalled last result does not hold off the next byte.
`default_nettype none

module serial_command_frame_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire scfp_pkg::scfp_req_type  req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output scfp_pkg::scfp_rsp_type      rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [31:0]            csr_data
);
   import scfp_pkg::*;

   `include "assert_macros.svh"

   scfp_cmd_type  cmd;
   scfp_stat_type stat;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   // Frame state machine
   scfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Timing, frame fields, store and output register
   scfp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Checks
   `ASSERT_CLK(a_mid_frame_holds_input, clock, reset,
      rsp_valid && !rsp_data.last |-> req_stall, "byte accepted in the middle of a frame")
   `ASSERT_CLK(a_empty_frame_shape, clock, reset,
      rsp_valid && !rsp_data.has_payload |->
         rsp_data.last && rsp_data.payload_byte == 8'h00 && rsp_data.payload_length == 7'd0,
      "empty frame result malformed")
   `ASSERT_CLK(a_index_in_range, clock, reset,
      rsp_valid && rsp_data.has_payload |->
         7'(rsp_data.payload_index) < rsp_data.payload_length, "payload index beyond length")

endmodule

`default_nettype wire

[hdl/scfp_ctrl.sv]
// Parser and result sequencing state machine for the serial command frame parser.
`default_nettype none

module scfp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire scfp_pkg::scfp_stat_type stat,
   output scfp_pkg::scfp_cmd_type      cmd
);
   import scfp_pkg::*;

   localparam logic [3:0] StHunt      = 4'd0;
   localparam logic [3:0] StWantProto = 4'd1;
   localparam logic [3:0] StWantDir   = 4'd2;
   localparam logic [3:0] StLength    = 4'd3;
   localparam logic [3:0] StCommand   = 4'd4;
   localparam logic [3:0] StPayload   = 4'd5;
   localparam logic [3:0] StCheck     = 4'd6;
   localparam logic [3:0] StFetch     = 4'd7;
   localparam logic [3:0] StSend      = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic [3:0] phase;
   logic       accept;

   // Input is held off while a frame is being emitted
   assign req_stall = (state_ff == StFetch) || (state_ff == StSend);
   assign accept    = req_valid && !req_stall;

   // Byte gap timeout forces hunting before the byte is examined
   assign phase = stat.timed_out ? StHunt : state_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      if (accept) begin
         cmd.capture_time = 1'b1;
         unique case (phase)
            StHunt: begin
               state_in = stat.is_start ? StWantProto : StHunt;
            end
            StWantProto: begin
               state_in = stat.is_proto ? StWantDir : StHunt;
            end
            StWantDir: begin
               if (stat.is_dir) begin
                  cmd.clear_frame = 1'b1;
                  state_in        = StLength;
               end else begin
                  state_in = StHunt;
               end
            end
            StLength: begin
               if (stat.length_ok) begin
                  cmd.load_length = 1'b1;
                  state_in        = StCommand;
               end else begin
                  state_in = StHunt;
               end
            end
            StCommand: begin
               cmd.load_command = 1'b1;
               state_in         = stat.length_zero ? StCheck : StPayload;
            end
            StPayload: begin
               cmd.store_payload = 1'b1;
               state_in          = stat.fill_done ? StCheck : StPayload;
            end
            StCheck: begin
               if (stat.xor_match) begin
                  cmd.start_emit = 1'b1;
                  state_in       = StFetch;
               end else begin
                  state_in = StHunt;
               end
            end
            default: begin
               state_in = StHunt;
            end
         endcase
      end else begin
         unique case (state_ff)
            StFetch: begin
               cmd.fetch = 1'b1;
               state_in  = StSend;
            end
            StSend: begin
               if (stat.can_load) begin
                  cmd.send = 1'b1;
                  state_in = stat.emit_last ? StHunt : StFetch;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StHunt;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hdl/scfp_dp.sv]
// Datapath of the serial command frame parser: timing, frame fields, payload store, output register.
`default_nettype none

module scfp_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire scfp_pkg::scfp_req_type  req_data,
   input  wire scfp_pkg::scfp_cmd_type  cmd,
   output scfp_pkg::scfp_stat_type     stat,
   input  wire logic                   csr_valid,
   input  wire logic [31:0]            csr_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output scfp_pkg::scfp_rsp_type      rsp_data
);
   import scfp_pkg::*;

   logic [31:0]        timeout_ff, timeout_in;
   logic [31:0]        arrival_ff, arrival_in;
   logic [6:0]         length_ff, length_in;
   logic [7:0]         command_ff, command_in;
   logic [7:0]         xor_ff, xor_in;
   logic [6:0]         fill_ff, fill_in;
   logic [StoreAw-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]         mem_q_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   scfp_rsp_type       rsp_ff, rsp_in;
   logic [7:0]         payload_mem [StoreDepth];

   logic [31:0]        gap;
   logic [7:0]         fill_next;
   logic [6:0]         rd_next;
   logic [7:0]         b;

   assign b         = req_data.rx_byte;
   assign gap       = req_data.now_us - arrival_ff;
   assign fill_next = {1'b0, fill_ff} + 8'd1;
   assign rd_next   = {1'b0, rd_idx_ff} + 7'd1;

   // Status toward the controller
   always_comb begin
      stat.timed_out   = gap > timeout_ff;
      stat.is_start    = b == StartByte;
      stat.is_proto    = b == ProtoByte;
      stat.is_dir      = b == DirByte;
      stat.length_ok   = (b <= 8'(MaxPayload)) && (b <= 8'(StoreDepth));
      stat.length_zero = length_ff == 7'd0;
      stat.fill_done   = fill_next >= {1'b0, length_ff};
      stat.xor_match   = xor_ff == b;
      stat.emit_last   = (length_ff == 7'd0) || (rd_next == length_ff);
      stat.can_load    = !rsp_valid_ff || !rsp_stall;
   end

   // Register next values
   always_comb begin
      timeout_in   = csr_valid ? csr_data : timeout_ff;
      arrival_in   = cmd.capture_time ? req_data.now_us : arrival_ff;
      length_in    = length_ff;
      command_in   = command_ff;
      xor_in       = xor_ff;
      fill_in      = fill_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.clear_frame) begin
         xor_in    = 8'd0;
         length_in = 7'd0;
      end
      if (cmd.load_length) begin
         length_in = b[6:0];
         fill_in   = 7'd0;
         xor_in    = xor_ff ^ b;
      end
      if (cmd.load_command) begin
         command_in = b;
         xor_in     = xor_ff ^ b;
      end
      if (cmd.store_payload) begin
         xor_in  = xor_ff ^ b;
         fill_in = fill_next[6:0];
      end
      if (cmd.start_emit) begin
         rd_idx_in = '0;
      end
      if (cmd.send) begin
         rsp_in.cmd_code       = command_ff;
         rsp_in.payload_length = length_ff;
         rsp_in.has_payload    = !stat.length_zero;
         rsp_in.payload_index  = 6'(rd_idx_ff);
         rsp_in.payload_byte   = stat.length_zero ? 8'd0 : mem_q_ff;
         rsp_in.last           = stat.emit_last;
         rsp_valid_in          = 1'b1;
         rd_idx_in             = rd_next[StoreAw-1:0];
      end
   end

   // Control and frame registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TimeoutReset;
         arrival_ff   <= 32'd0;
         length_ff    <= 7'd0;
         command_ff   <= 8'd0;
         xor_ff       <= 8'd0;
         fill_ff      <= 7'd0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         timeout_ff   <= timeout_in;
         arrival_ff   <= arrival_in;
         length_ff    <= length_in;
         command_ff   <= command_in;
         xor_ff       <= xor_in;
         fill_ff      <= fill_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Payload store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.store_payload) begin
         payload_mem[fill_ff[StoreAw-1:0]] <= b;
      end
      if (cmd.fetch) begin
         mem_q_ff <= payload_mem[rd_idx_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
